### src/skt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// skt_pkg: shared types and helpers for the sorted key table
// Holds table size, command and status codes, channel payloads, the control
// group sent along the cell row and the thermometer count helper.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_FIND   = 2'd1,
    CMD_REMOVE = 2'd2
  } skt_cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } skt_status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } skt_state_e;

  typedef struct packed {
    logic [1:0]        cmd;
    logic signed [31:0] key;
  } skt_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] position;
    logic [4:0] entry_count;
  } skt_res_t;

  // control broadcast to every cell
  typedef struct packed {
    logic sample;  // capture compare flags
    logic ins;     // open a slot and write the new key
    logic rem;     // close the gap at the first equal key
  } skt_ctrl_t;

  typedef struct packed {
    logic lt;  // held key below search key
    logic le;  // held key at or below search key
  } skt_flag_t;

  // number of ones in a thermometer code (ones packed at the low end)
  function automatic logic [CNT_W-1:0] therm_count(input logic [CAPACITY-1:0] t);
    logic [CAPACITY:0] t_ext;
    logic [CNT_W-1:0]  cnt;
    t_ext = {1'b0, t};
    cnt   = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (t_ext[i] && !t_ext[i+1]) begin
        cnt = cnt | CNT_W'(i + 1);
      end
    end
    return cnt;
  endfunction

endpackage
`default_nettype wire

### src/skt_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// skt_cell: one entry of the sorted key row
// Holds one key, compares it with the broadcast key and shifts in a key
// from the left or right neighbor when an insert or remove moves the row.
// ----------------------------------------------------------------------------
module skt_cell (
  input  wire logic               clk_i,
  input  wire skt_pkg::skt_ctrl_t ctrl_i,
  input  wire logic signed [31:0] cmp_key_i,
  input  wire logic signed [31:0] new_key_i,
  input  wire logic               used_i,
  input  wire logic               left_le_i,
  input  wire logic signed [31:0] left_key_i,
  input  wire logic signed [31:0] right_key_i,
  output skt_pkg::skt_flag_t      flag_o,
  output logic signed [31:0]      key_o
);

  logic signed [31:0] key_q;
  skt_pkg::skt_flag_t flag_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sample) begin
      flag_q.lt <= used_i && (key_q < cmp_key_i);
      flag_q.le <= used_i && (key_q <= cmp_key_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ins && !flag_q.le) begin
      // first cell above the slot takes the new key, the rest move up
      key_q <= left_le_i ? new_key_i : left_key_i;
    end else if (ctrl_i.rem && !flag_q.lt) begin
      key_q <= right_key_i;
    end
  end

  assign flag_o = flag_q;
  assign key_o  = key_q;

endmodule
`default_nettype wire

### src/sorted_key_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_key_table: bounded table of signed keys in ascending order
// Insert, find and remove over a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_i (cmd, key) and raise start while busy is low; the item is
//   taken at that clock edge. busy stays high for the following cycle.
//   The result (status, position, entry_count) is marked on res_o by done_o,
//   which is high for exactly one cycle once the execute cycle ends.
//   The accepting edge registers the per-cell compare flags; the execute
//   cycle counts the flag thermometers to get the position and moves the
//   cell row in one step. No item is taken while busy is high; the next item
//   can be taken in the cycle in which the previous result is shown.
//   The receiver cannot stall: done_o is a strobe, and res_o holds the
//   result only until the next result is registered.
//   Insert puts the key after all equal keys; on a full table it is dropped
//   with status full. Find and remove report the first equal key; command
//   code 3 reports not found and changes nothing.
//   Reset empties the table at once (the entry count is cleared); no
//   clearing pass is needed, only entries below the count are ever used.
// ----------------------------------------------------------------------------
module sorted_key_table (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire skt_pkg::skt_req_t req_i,
  output logic                   done_o,
  output skt_pkg::skt_res_t      res_o
);

  localparam int N = skt_pkg::CAPACITY;
  localparam int W = skt_pkg::CNT_W;

  skt_pkg::skt_state_e  state_q, state_d;
  logic [W-1:0]         count_q, count_d;
  logic [1:0]           cmd_q;
  logic signed [31:0]   key_q;
  logic                 done_q, done_d;
  skt_pkg::skt_res_t    res_q, res_d;
  skt_pkg::skt_ctrl_t   ctrl;

  logic                 accept;
  logic [N-1:0]         lt_vec, le_vec, used;
  logic signed [31:0]   cell_key [N];
  skt_pkg::skt_flag_t   cell_flag [N];
  logic [W-1:0]         n_lt, n_le;
  logic [W-1:0]         pos_sel;
  logic                 full, hit;

  assign accept = start && !busy;
  assign busy   = (state_q == skt_pkg::S_EXEC);

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic               left_le;
    logic signed [31:0] left_key, right_key;

    assign used[i] = (count_q > W'(i));

    if (i == 0) begin : g_head
      assign left_le  = 1'b1;
      assign left_key = key_q;
    end else begin : g_body
      assign left_le  = cell_flag[i-1].le;
      assign left_key = cell_key[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign right_key = cell_key[i];
    end else begin : g_inner
      assign right_key = cell_key[i+1];
    end

    skt_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .cmp_key_i   (req_i.key),
      .new_key_i   (key_q),
      .used_i      (used[i]),
      .left_le_i   (left_le),
      .left_key_i  (left_key),
      .right_key_i (right_key),
      .flag_o      (cell_flag[i]),
      .key_o       (cell_key[i])
    );

    assign lt_vec[i] = cell_flag[i].lt;
    assign le_vec[i] = cell_flag[i].le;
  end

  assign n_lt = skt_pkg::therm_count(lt_vec);
  assign n_le = skt_pkg::therm_count(le_vec);
  assign full = (count_q >= W'(N));
  assign hit  = (n_le != n_lt);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    done_d      = 1'b0;
    res_d       = res_q;
    ctrl.sample = 1'b0;
    ctrl.ins    = 1'b0;
    ctrl.rem    = 1'b0;
    pos_sel     = '0;
    case (state_q)
      skt_pkg::S_IDLE: begin
        if (accept) begin
          ctrl.sample = 1'b1;
          state_d     = skt_pkg::S_EXEC;
        end
      end
      skt_pkg::S_EXEC: begin
        state_d      = skt_pkg::S_IDLE;
        done_d       = 1'b1;
        res_d.status = skt_pkg::ST_NOT_FOUND;
        case (cmd_q)
          skt_pkg::CMD_INSERT: begin
            if (full) begin
              res_d.status = skt_pkg::ST_FULL;
            end else begin
              ctrl.ins     = 1'b1;
              count_d      = count_q + W'(1);
              pos_sel      = n_le;
              res_d.status = skt_pkg::ST_OK;
            end
          end
          skt_pkg::CMD_FIND: begin
            if (hit) begin
              pos_sel      = n_lt;
              res_d.status = skt_pkg::ST_OK;
            end
          end
          skt_pkg::CMD_REMOVE: begin
            if (hit) begin
              ctrl.rem     = 1'b1;
              count_d      = count_q - W'(1);
              pos_sel      = n_lt;
              res_d.status = skt_pkg::ST_OK;
            end
          end
          default: begin
            res_d.status = skt_pkg::ST_NOT_FOUND;
          end
        endcase
        res_d.position    = 4'(pos_sel);
        res_d.entry_count = 5'(count_d);
      end
      default: begin
        state_d = skt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= skt_pkg::S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  // hold the item for the execute cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= req_i.cmd;
      key_q <= req_i.key;
    end
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= W'(N))
    else $error("entry count above capacity");

  a_done_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == skt_pkg::S_EXEC))
    else $error("result strobe without an execute cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy && done_d)
    else $error("accepted item not executed in the next cycle");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |=> $stable(count_q))
    else $error("entry count changed outside execute");

  a_thermometer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (n_lt <= n_le) && (n_le <= count_q))
    else $error("compare flags not ordered");

endmodule
`default_nettype wire

### test/sorted_key_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table_tb: self-checking bench for the sorted key table
// Walks a short table of directed items (empty table, extreme keys, equal
// keys, head and tail removal, full table, unused command), then runs three
// random phases with different sender idling. Every accepted item goes
// through a local model of the table, and each strobed result is checked
// field by field against the oldest pending expected result.
// ----------------------------------------------------------------------------
module sorted_key_table_tb;

  localparam int                 WATCHDOG_LIMIT = 1000;
  localparam int                 PHASE_ITEMS    = 417;
  localparam logic [1:0]         CMD_UNUSED     = 2'd3;
  localparam logic signed [31:0] KEY_MIN        = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX        = 32'sh7fff_ffff;

  typedef struct {
    skt_pkg::skt_req_t req;
    bit                typed;
    skt_pkg::skt_res_t res;
  } plan_row_t;

  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              start     = 1'b0;
  skt_pkg::skt_req_t req       = '0;
  bit                row_typed = 1'b0;
  skt_pkg::skt_res_t row_res   = '0;
  logic              busy;
  logic              done_o;
  skt_pkg::skt_res_t res_o;

  // local copy of the table, advanced on every accepted item
  logic signed [31:0] model_keys [skt_pkg::CAPACITY];
  int                 model_held = 0;

  skt_pkg::skt_res_t pending_results [$];
  skt_pkg::skt_res_t predicted;
  skt_pkg::skt_res_t want;
  int                mismatches  = 0;
  int                quiet_count = 0;
  plan_row_t         plan [$];

  sorted_key_table dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req),
    .done_o (done_o),
    .res_o  (res_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic skt_pkg::skt_res_t apply_op(input skt_pkg::skt_req_t r);
    skt_pkg::skt_res_t o;
    int                at;
    int                slot;
    o.status   = skt_pkg::ST_NOT_FOUND;
    o.position = '0;
    at         = -1;
    for (int i = model_held - 1; i >= 0; i--) begin
      if (model_keys[i] == r.key) at = i;
    end
    case (r.cmd)
      skt_pkg::CMD_INSERT: begin
        if (model_held >= skt_pkg::CAPACITY) begin
          o.status = skt_pkg::ST_FULL;
        end else begin
          slot = 0;
          while (slot < model_held && model_keys[slot] <= r.key) slot++;
          for (int i = model_held; i > slot; i--) model_keys[i] = model_keys[i-1];
          model_keys[slot] = r.key;
          model_held++;
          o.status   = skt_pkg::ST_OK;
          o.position = 4'(slot);
        end
      end
      skt_pkg::CMD_FIND: begin
        if (at >= 0) begin
          o.status   = skt_pkg::ST_OK;
          o.position = 4'(at);
        end
      end
      skt_pkg::CMD_REMOVE: begin
        if (at >= 0) begin
          for (int i = at; i < model_held - 1; i++) model_keys[i] = model_keys[i+1];
          model_held--;
          o.status   = skt_pkg::ST_OK;
          o.position = 4'(at);
        end
      end
      default: ;
    endcase
    o.entry_count = 5'(model_held);
    return o;
  endfunction

  function automatic plan_row_t plan_row(input logic [1:0] cmd, input logic signed [31:0] key,
                                         input bit typed, input logic [1:0] status,
                                         input int pos, input int cnt);
    plan_row_t p;
    p.req.cmd         = cmd;
    p.req.key         = key;
    p.typed           = typed;
    p.res.status      = status;
    p.res.position    = 4'(pos);
    p.res.entry_count = 5'(cnt);
    return p;
  endfunction

  // result check and prediction, both sampled at the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        if (pending_results.size() == 0) begin
          $error("result with no item pending: %p", res_o);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (res_o.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, res_o.status);
            mismatches++;
          end
          if (res_o.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, res_o.position);
            mismatches++;
          end
          if (res_o.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   res_o.entry_count);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        predicted = apply_op(req);
        pending_results.push_back(row_typed ? row_res : predicted);
      end
      if (done_o || (start && !busy)) quiet_count = 0;
      else quiet_count++;
    end
  end

  initial begin
    while (quiet_count < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("Verification failed");
    $finish;
  end

  // hold start low for a random number of cycles, then offer the item until taken
  task automatic send_item(input skt_pkg::skt_req_t r, input bit typed,
                           input skt_pkg::skt_res_t tres, input int idle_pct);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start     <= 1'b1;
    req       <= r;
    row_typed <= typed;
    row_res   <= tres;
    do @(posedge clk_i); while (busy);
  endtask

  // stop sending until every predicted result has come back
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  initial begin
    logic signed [31:0] key_pool [8];
    skt_pkg::skt_req_t  item;
    int                 idle_pct;
    int                 insert_pct;
    int                 pick;

    plan.push_back(plan_row(skt_pkg::CMD_FIND,   32'sd0,  1, skt_pkg::ST_NOT_FOUND, 0, 0));
    plan.push_back(plan_row(skt_pkg::CMD_REMOVE, 32'sd5,  1, skt_pkg::ST_NOT_FOUND, 0, 0));
    plan.push_back(plan_row(CMD_UNUSED,          -32'sd1, 1, skt_pkg::ST_NOT_FOUND, 0, 0));
    plan.push_back(plan_row(skt_pkg::CMD_INSERT, KEY_MIN, 1, skt_pkg::ST_OK, 0, 1));
    plan.push_back(plan_row(skt_pkg::CMD_INSERT, KEY_MAX, 1, skt_pkg::ST_OK, 1, 2));
    plan.push_back(plan_row(skt_pkg::CMD_INSERT, 32'sd0,  1, skt_pkg::ST_OK, 1, 3));
    // equal key goes after the one already held
    plan.push_back(plan_row(skt_pkg::CMD_INSERT, 32'sd0,  1, skt_pkg::ST_OK, 2, 4));
    plan.push_back(plan_row(skt_pkg::CMD_FIND,   32'sd0,  1, skt_pkg::ST_OK, 1, 4));
    // remove the head entry
    plan.push_back(plan_row(skt_pkg::CMD_REMOVE, KEY_MIN, 1, skt_pkg::ST_OK, 0, 3));
    plan.push_back(plan_row(skt_pkg::CMD_INSERT, -32'sd1, 0, skt_pkg::ST_OK, 0, 0));
    plan.push_back(plan_row(skt_pkg::CMD_INSERT, 32'sd7,  0, skt_pkg::ST_OK, 0, 0));
    plan.push_back(plan_row(skt_pkg::CMD_INSERT, 32'sd7,  0, skt_pkg::ST_OK, 0, 0));
    plan.push_back(plan_row(skt_pkg::CMD_INSERT, -32'sd7, 0, skt_pkg::ST_OK, 0, 0));
    plan.push_back(plan_row(skt_pkg::CMD_INSERT, 32'sd100, 0, skt_pkg::ST_OK, 0, 0));
    plan.push_back(plan_row(skt_pkg::CMD_INSERT, -32'sd100, 0, skt_pkg::ST_OK, 0, 0));
    plan.push_back(plan_row(skt_pkg::CMD_INSERT, 32'sh4000_0000, 0, skt_pkg::ST_OK, 0, 0));
    plan.push_back(plan_row(skt_pkg::CMD_INSERT, -32'sd2, 0, skt_pkg::ST_OK, 0, 0));
    plan.push_back(plan_row(skt_pkg::CMD_INSERT, 32'sd1,  0, skt_pkg::ST_OK, 0, 0));
    plan.push_back(plan_row(skt_pkg::CMD_INSERT, 32'sd1,  0, skt_pkg::ST_OK, 0, 0));
    plan.push_back(plan_row(skt_pkg::CMD_INSERT, 32'sd50, 0, skt_pkg::ST_OK, 0, 0));
    plan.push_back(plan_row(skt_pkg::CMD_INSERT, -32'sd50, 0, skt_pkg::ST_OK, 0, 0));
    plan.push_back(plan_row(skt_pkg::CMD_INSERT, 32'sd3,  0, skt_pkg::ST_OK, 0, 0));
    // table now full: insert is dropped
    plan.push_back(plan_row(skt_pkg::CMD_INSERT, 32'sd9,  1, skt_pkg::ST_FULL, 0, 16));
    plan.push_back(plan_row(skt_pkg::CMD_FIND,   KEY_MAX, 1, skt_pkg::ST_OK, 15, 16));
    plan.push_back(plan_row(skt_pkg::CMD_REMOVE, KEY_MAX, 1, skt_pkg::ST_OK, 15, 15));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) send_item(plan[i].req, plan[i].typed, plan[i].res, 23);

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 23 : (phase == 1) ? 75 : 0;
      drain_results();
      foreach (key_pool[j]) begin
        case ($urandom_range(3))
          0:       key_pool[j] = $urandom_range(1) ? KEY_MAX : KEY_MIN;
          1:       key_pool[j] = $signed(32'($urandom_range(8))) - 32'sd4;
          default: key_pool[j] = $urandom;
        endcase
      end
      insert_pct = 65;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // swing between filling and emptying the table
        if (n % 48 == 47) insert_pct = (insert_pct == 65) ? 25 : 65;
        pick = $urandom_range(99);
        if (pick < 3) item.cmd = CMD_UNUSED;
        else if (pick < 3 + insert_pct) item.cmd = skt_pkg::CMD_INSERT;
        else if (pick % 2 == 0) item.cmd = skt_pkg::CMD_FIND;
        else item.cmd = skt_pkg::CMD_REMOVE;
        pick = $urandom_range(9);
        if (pick < 5 || (pick < 7 && model_held == 0)) begin
          item.key = key_pool[$urandom_range(7)];
        end else if (pick < 7) begin
          item.key = model_keys[$urandom_range(model_held - 1)];
        end else begin
          item.key = $urandom;
        end
        send_item(item, 1'b0, '0, idle_pct);
      end
    end

    drain_results();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
